/* hdl/u8sd_pkg.sv */
package u8sd_pkg;

    localparam int unsigned PendDepth = 5;
    localparam int unsigned CpW       = 32;
    localparam int unsigned LenW      = 3;
    localparam int unsigned OutDataW  = 40;

    typedef logic [7:0] byte_t;

    // results produced by one input item: buffered bytes given back raw,
    // then an optional final result
    typedef struct packed {
        byte_t [PendDepth-1:0] raw;
        logic [LenW-1:0]       nraw;
        logic                  fin;
        logic [CpW-1:0]        cp;
        logic [LenW-1:0]       len;
        logic                  inv;
    } burst_t;

    // sequence length announced by a lead; 0 for a continuation byte
    function automatic logic [LenW-1:0] lead_len(input byte_t b);
        logic [LenW-1:0] r;
        r = 3'd0;
        if (b[7] == 1'b0)
            r = 3'd1;
        else if (b[7:5] == 3'b110)
            r = 3'd2;
        else if (b[7:4] == 4'b1110)
            r = 3'd3;
        else if (b[7:3] == 5'b11110)
            r = 3'd4;
        else if (b[7:2] == 6'b111110)
            r = 3'd5;
        else if (b[7:2] == 6'b111111)
            r = 3'd6;
        return r;
    endfunction

endpackage

/* hdl/u8sd_step.sv */
module u8sd_step
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  u8sd_pkg::byte_t   in_byte,
    input  logic              end_of_text,
    output logic              burst_valid,
    output u8sd_pkg::burst_t  burst
);

    u8sd_pkg::byte_t pend_reg [u8sd_pkg::PendDepth];
    logic [2:0]      pcount_reg, pcount_next;
    logic [2:0]      elen_reg, elen_next;

    logic            is_cont;
    logic            fresh;
    logic            do_lead;
    logic            wr_en;
    logic [2:0]      wr_idx;
    logic [2:0]      blen;
    logic [31:0]     seq_cp;

    assign is_cont = (in_byte[7:6] == 2'b10);
    assign fresh   = (pcount_reg == 3'd0) || (pcount_reg >= elen_reg);
    assign blen    = u8sd_pkg::lead_len(in_byte);

    always_comb
    begin
        case (elen_reg)
            3'd2: seq_cp = 32'({pend_reg[0][4:0], in_byte[5:0]});
            3'd3: seq_cp = 32'({pend_reg[0][3:0], pend_reg[1][5:0], in_byte[5:0]});
            3'd4: seq_cp = 32'({pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                                in_byte[5:0]});
            3'd5: seq_cp = 32'({pend_reg[0][1:0], pend_reg[1][5:0], pend_reg[2][5:0],
                                pend_reg[3][5:0], in_byte[5:0]});
            3'd6: seq_cp = {pend_reg[0][1:0], pend_reg[1][5:0], pend_reg[2][5:0],
                            pend_reg[3][5:0], pend_reg[4][5:0], in_byte[5:0]};
            default: seq_cp = 32'(in_byte);
        endcase
    end

    always_comb
    begin
        pcount_next = pcount_reg;
        elen_next   = elen_reg;
        wr_en       = 1'b0;
        wr_idx      = pcount_reg;
        do_lead     = 1'b0;
        for (int i = 0; i < u8sd_pkg::PendDepth; i++)
        begin
            burst.raw[i] = pend_reg[i];
        end
        burst.nraw = 3'd0;
        burst.fin  = 1'b0;
        burst.cp   = 32'(in_byte);
        burst.len  = 3'd1;
        burst.inv  = 1'b1;

        if (fresh)
        begin
            do_lead = 1'b1;
        end
        else if (is_cont)
        begin
            if ((pcount_reg + 3'd1) == elen_reg)
            begin
                burst.fin   = 1'b1;
                burst.cp    = seq_cp;
                burst.len   = elen_reg;
                burst.inv   = 1'b0;
                pcount_next = 3'd0;
                elen_next   = 3'd0;
            end
            else if (end_of_text)
            begin
                burst.nraw  = pcount_reg;
                burst.fin   = 1'b1;
                pcount_next = 3'd0;
                elen_next   = 3'd0;
            end
            else
            begin
                wr_en       = 1'b1;
                pcount_next = pcount_reg + 3'd1;
            end
        end
        else
        begin
            burst.nraw = pcount_reg;
            do_lead    = 1'b1;
        end

        if (do_lead)
        begin
            pcount_next = 3'd0;
            elen_next   = 3'd0;
            if (blen == 3'd1)
            begin
                burst.fin = 1'b1;
                burst.inv = 1'b0;
            end
            else if ((blen == 3'd0) || end_of_text)
            begin
                burst.fin = 1'b1;
            end
            else
            begin
                wr_en       = 1'b1;
                wr_idx      = 3'd0;
                pcount_next = 3'd1;
                elen_next   = blen;
            end
        end
    end

    assign burst_valid = burst.fin || (burst.nraw != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 3'd0;
            elen_reg   <= 3'd0;
        end
        else if (accept)
        begin
            pcount_reg <= pcount_next;
            elen_reg   <= elen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            pend_reg[wr_idx] <= in_byte;
        end
    end

`ifndef SYNTHESIS
    // a partial sequence is always shorter than its announced length
    a_partial_short: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg != 3'd0 |-> pcount_reg < elen_reg && elen_reg >= 3'd2 && elen_reg <= 3'd6)
        else $error("pending count out of range");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pcount_reg) && $stable(elen_reg))
        else $error("decoder state changed without an item");
`endif

endmodule

/* hdl/utf8_stream_decoder.sv */
// A result passes the burst register, which holds the item's results, then the output
// register. Throughput: 1 item per cycle while each byte gives at most one result and
// the output is not stalled; a byte that gives more (an interrupted sequence, up to 6)
// holds input while the single result register drains its burst, one result per cycle unless stalled.
// Reset: asynchronous, active low; clears the partial sequence and all valid flags.
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] code_point, [34:32] seq_length, rest zero
    output logic        m_axis_tuser,   // invalid
    output logic        m_axis_tlast    // run_last
);

    logic              accept;
    logic              step_valid;
    u8sd_pkg::burst_t  step_burst;

    u8sd_pkg::burst_t  burst_reg;
    logic              bvalid_reg, bvalid_next;
    logic [2:0]        idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_cp_reg;
    logic [2:0]        out_len_reg;
    logic              out_inv_reg;
    logic              out_last_reg;

    logic              pop;
    logic              is_raw;
    logic              last_pop;
    logic [31:0]       pop_cp;
    logic [2:0]        pop_len;
    logic              pop_inv;

    u8sd_step u_step
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .burst_valid (step_valid),
        .burst       (step_burst)
    );

    assign pop    = bvalid_reg && (!out_valid_reg || m_axis_tready);
    assign is_raw = idx_reg < burst_reg.nraw;

    always_comb
    begin
        if (is_raw)
        begin
            pop_cp   = 32'(burst_reg.raw[idx_reg]);
            pop_len  = 3'd1;
            pop_inv  = 1'b1;
            last_pop = ((idx_reg + 3'd1) == burst_reg.nraw) && !burst_reg.fin;
        end
        else
        begin
            pop_cp   = burst_reg.cp;
            pop_len  = burst_reg.len;
            pop_inv  = burst_reg.inv;
            last_pop = 1'b1;
        end
    end

    assign s_axis_tready = !bvalid_reg || (pop && last_pop);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        bvalid_next = bvalid_reg;
        idx_next    = idx_reg;
        if (pop)
        begin
            if (last_pop)
            begin
                bvalid_next = 1'b0;
                idx_next    = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (accept && step_valid)
        begin
            bvalid_next = 1'b1;
            idx_next    = 3'd0;
        end
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg    <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bvalid_reg    <= bvalid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step_valid)
        begin
            burst_reg <= step_burst;
        end
        if (pop)
        begin
            out_cp_reg   <= pop_cp;
            out_len_reg  <= pop_len;
            out_inv_reg  <= pop_inv;
            out_last_reg <= last_pop;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_len_reg, out_cp_reg};
    assign m_axis_tuser  = out_inv_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid_reg |-> (burst_reg.fin || burst_reg.nraw != 3'd0) && burst_reg.nraw <= 3'd5)
        else $error("empty or oversized burst held");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid_reg |-> idx_reg <= burst_reg.nraw)
        else $error("burst index past the end");

    a_burst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid_reg && !pop |-> !s_axis_tready ##1 (bvalid_reg && $stable(idx_reg)))
        else $error("stalled burst moved or input opened");

    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_inv_reg |-> out_len_reg >= 3'd1 && out_len_reg <= 3'd6)
        else $error("decoded length out of range");
`endif

endmodule
